FILE: hdl/hcr_pkg.sv
// ----------------------------------------------------------------------------
// hcr_pkg
// Shared constants, types and helpers of the Harris corner response unit.
// ----------------------------------------------------------------------------
package hcr_pkg;

   localparam int DEF_MAX_WIDTH   = 1024;
   localparam int RING_ROWS       = 8;
   localparam int RING_BITS       = 3;
   localparam int HEIGHT_LIMIT    = 1024;
   localparam int ROW_BITS        = 10;
   localparam int HGT_BITS        = 11;
   localparam int FW_BITS         = 11;
   localparam int K_BITS          = 15;
   localparam int CSR_DATA_BITS   = 15;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int PIX_BITS        = 8;
   localparam int GRAD_BITS       = 11;
   localparam int SUM_BITS        = 24;
   localparam int PROD_BITS       = 48;
   localparam int VAL_BITS        = 49;
   localparam int RESP_BITS       = 45;
   localparam int RESP_DATA_BITS  = 48;
   localparam int QUEUE_DEPTH     = 2;
   localparam int MIR_BITS        = 14;

   localparam logic [K_BITS-1:0]   K_RESET  = 15'd2621;
   localparam logic [FW_BITS-1:0]  FW_RESET = 11'd640;
   localparam logic [HGT_BITS-1:0] FH_RESET = 11'd480;

   localparam logic signed [VAL_BITS-1:0] RESP_LIMIT = 49'sd17318914560000;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_K_GAIN       = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 2'd2;

   typedef logic signed [MIR_BITS-1:0] mir_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_RUN,
      BK_WAIT1,
      BK_WAIT2,
      BK_MUL1,
      BK_MUL2,
      BK_FIN,
      BK_OUT
   } back_state_type;

   // reflect an index one step outside [0, n) back inside, edge not repeated
   function automatic mir_type mirror(input mir_type i, input mir_type n);
      mir_type v;
      v = i;
      if (v < 0) v = -v;
      if (v >= n) v = mir_type'(2 * n - 2) - v;
      if (v < 0) v = '0;
      return v;
   endfunction

endpackage

FILE: hdl/hcr_ram.sv
// ----------------------------------------------------------------------------
// hcr_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module hcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/hcr_fifo.sv
// ----------------------------------------------------------------------------
// hcr_fifo
// Short first-word-fall-through queue of pending response jobs.
// ----------------------------------------------------------------------------
module hcr_fifo #(
   parameter int WIDTH = 21,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty,
   output logic             full
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CW'(DEPTH));

endmodule

FILE: hdl/hcr_front.sv
// ----------------------------------------------------------------------------
// hcr_front
// Accept words, store pixels in the line ring, queue response jobs.
// ----------------------------------------------------------------------------
module hcr_front #(
   parameter int MAX_WIDTH = hcr_pkg::DEF_MAX_WIDTH
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [hcr_pkg::PIX_BITS-1:0]              req_tdata,
   input  logic                                      req_tuser,
   input  logic [hcr_pkg::FW_BITS-1:0]               frame_width,
   input  logic [hcr_pkg::HGT_BITS-1:0]              frame_height,
   output logic                                      ram_wr_en,
   output logic [hcr_pkg::RING_BITS+$clog2(MAX_WIDTH)-1:0] ram_wr_addr,
   output logic [hcr_pkg::PIX_BITS-1:0]              ram_wr_data,
   output logic [$clog2(MAX_WIDTH+1)-1:0]            act_width,
   output logic [hcr_pkg::HGT_BITS-1:0]              act_height,
   output logic                                      job_push,
   output logic [hcr_pkg::ROW_BITS+$clog2(MAX_WIDTH):0] job_data,
   input  logic                                      job_full,
   input  logic                                      job_empty,
   input  logic                                      back_idle
);
   import hcr_pkg::*;

   localparam int CI = $clog2(MAX_WIDTH);
   localparam int WB = $clog2(MAX_WIDTH + 1);
   localparam int LB = $clog2(2 * MAX_WIDTH + 3);

   logic              started_ff, started_in;
   logic              pix_done_ff, pix_done_in;
   logic [LB-1:0]     cnt_ff, cnt_in;
   logic [ROW_BITS-1:0] wrow_ff, wrow_in, prow_ff, prow_in;
   logic [CI-1:0]     wcol_ff, wcol_in, pcol_ff, pcol_in;
   logic [WB-1:0]     width_ff, width_in, eff_w, clamp_w;
   logic [HGT_BITS-1:0] height_ff, height_in, eff_h, clamp_h;
   logic [LB-1:0]     lat;
   logic              take, work, wlast_col, wlast, plast_col, frame_end;

   always_comb begin
      int fw;
      int fh;
      fw = int'(frame_width);
      fh = int'(frame_height);
      if (fw < 3) fw = 3;
      if (fw > MAX_WIDTH) fw = MAX_WIDTH;
      if (fh < 3) fh = 3;
      if (fh > HEIGHT_LIMIT) fh = HEIGHT_LIMIT;
      clamp_w = WB'(fw);
      clamp_h = HGT_BITS'(fh);
   end

   assign req_tready = started_ff ? !job_full : (job_empty && back_idle);
   assign take       = req_tvalid && req_tready;
   assign work       = take && !(req_tuser && !pix_done_ff);
   assign eff_w      = started_ff ? width_ff : clamp_w;
   assign eff_h      = started_ff ? height_ff : clamp_h;
   assign lat        = LB'({eff_w, 1'b0}) + LB'(2);

   assign wlast_col  = (wcol_ff == CI'(eff_w - 1'b1));
   assign wlast      = wlast_col && (wrow_ff == ROW_BITS'(eff_h - 1'b1));
   assign plast_col  = (pcol_ff == CI'(eff_w - 1'b1));
   assign frame_end  = plast_col && (prow_ff == ROW_BITS'(eff_h - 1'b1));

   assign ram_wr_en   = work && !pix_done_ff;
   assign ram_wr_addr = {wrow_ff[RING_BITS-1:0], wcol_ff};
   assign ram_wr_data = req_tdata;
   assign job_push    = work && (cnt_ff >= lat);
   assign job_data    = {frame_end, prow_ff, pcol_ff};
   assign act_width   = width_ff;
   assign act_height  = height_ff;

   always_comb begin
      started_in  = started_ff;
      pix_done_in = pix_done_ff;
      cnt_in      = cnt_ff;
      wrow_in     = wrow_ff;
      wcol_in     = wcol_ff;
      prow_in     = prow_ff;
      pcol_in     = pcol_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      if (work) begin
         started_in = 1'b1;
         width_in   = eff_w;
         height_in  = eff_h;
         if (!pix_done_ff) begin
            wcol_in = wlast_col ? '0 : wcol_ff + 1'b1;
            if (wlast_col) wrow_in = wrow_ff + 1'b1;
            if (wlast) pix_done_in = 1'b1;
         end
         if (cnt_ff >= lat) begin
            pcol_in = plast_col ? '0 : pcol_ff + 1'b1;
            if (plast_col) prow_in = prow_ff + 1'b1;
            if (frame_end) begin
               started_in  = 1'b0;
               pix_done_in = 1'b0;
               cnt_in      = '0;
               wrow_in     = '0;
               wcol_in     = '0;
               prow_in     = '0;
               pcol_in     = '0;
            end
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff  <= 1'b0;
         pix_done_ff <= 1'b0;
         cnt_ff      <= '0;
         wrow_ff     <= '0;
         wcol_ff     <= '0;
         prow_ff     <= '0;
         pcol_ff     <= '0;
         width_ff    <= WB'(3);
         height_ff   <= HGT_BITS'(3);
      end else begin
         started_ff  <= started_in;
         pix_done_ff <= pix_done_in;
         cnt_ff      <= cnt_in;
         wrow_ff     <= wrow_in;
         wcol_ff     <= wcol_in;
         prow_ff     <= prow_in;
         pcol_ff     <= pcol_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
      end
   end

endmodule

FILE: hdl/hcr_back.sv
// ----------------------------------------------------------------------------
// hcr_back
// Read the stencil from the line ring, form gradients, window sums and the
// Harris response, and hold it in the output register.
// ----------------------------------------------------------------------------
module hcr_back #(
   parameter int MAX_WIDTH = hcr_pkg::DEF_MAX_WIDTH
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic [hcr_pkg::ROW_BITS+$clog2(MAX_WIDTH):0] job_data,
   input  logic                                      job_empty,
   output logic                                      job_pop,
   output logic                                      back_idle,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]            act_width,
   input  logic [hcr_pkg::HGT_BITS-1:0]              act_height,
   input  logic [hcr_pkg::K_BITS-1:0]                k_gain,
   output logic [hcr_pkg::RING_BITS+$clog2(MAX_WIDTH)-1:0] ram_rd_addr,
   input  logic [hcr_pkg::PIX_BITS-1:0]              ram_rd_data,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   output logic [hcr_pkg::RESP_DATA_BITS-1:0]        rsp_tdata,
   output logic                                      rsp_tlast
);
   import hcr_pkg::*;

   localparam int CI = $clog2(MAX_WIDTH);

   back_state_type state_ff, state_in;

   logic [ROW_BITS-1:0] row_ff;
   logic [CI-1:0]       col_ff;
   logic                fe_ff;
   mir_type             r0_ff, c0_ff;
   logic [1:0]          tr_ff, tc_ff, win_ff;
   logic                d_valid_ff;
   logic [1:0]          d_tr_ff, d_tc_ff;
   logic signed [GRAD_BITS-1:0] gx_acc_ff, gy_acc_ff, gx_in, gy_in, gx_ff, gy_ff;
   logic                g_valid_ff;
   logic signed [SUM_BITS-1:0]  sa_ff, sb_ff, sc_ff;
   logic signed [PROD_BITS-1:0] ac_ff, bb_ff;
   logic [PROD_BITS-1:0]        ss_ff;
   logic [38:0]                 hk_ff, lk_ff;
   logic [RESP_BITS-1:0]        res_ff;
   logic                        rsp_valid_ff;
   logic [RESP_BITS-1:0]        rsp_data_ff;
   logic                        rsp_last_ff;

   mir_type wr, wc, rr, cc, h_m, w_m;
   logic    last_issue, load_out;
   logic signed [GRAD_BITS-1:0] pix_s, gx_base, gy_base, mx, my;
   logic signed [SUM_BITS-1:0]  s_sum;
   logic [62:0]                 q_full;
   logic signed [VAL_BITS-1:0]  val;

   assign h_m = mir_type'(act_height);
   assign w_m = mir_type'(act_width);
   assign wr  = win_ff[1] ? mir_type'(row_ff) : r0_ff;
   assign wc  = win_ff[0] ? mir_type'(col_ff) : c0_ff;
   assign rr  = mirror(wr + mir_type'(tr_ff) - mir_type'(1), h_m);
   assign cc  = mirror(wc + mir_type'(tc_ff) - mir_type'(1), w_m);
   assign ram_rd_addr = {rr[RING_BITS-1:0], cc[CI-1:0]};

   assign last_issue = (win_ff == 2'd3) && (tr_ff == 2'd2) && (tc_ff == 2'd2);
   assign load_out   = (state_ff == BK_OUT) && (!rsp_valid_ff || rsp_tready);
   assign back_idle  = (state_ff == BK_IDLE);
   assign job_pop    = back_idle && !job_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:  if (!job_empty) state_in = BK_RUN;
         BK_RUN:   if (last_issue) state_in = BK_WAIT1;
         BK_WAIT1: state_in = BK_WAIT2;
         BK_WAIT2: state_in = BK_MUL1;
         BK_MUL1:  state_in = BK_MUL2;
         BK_MUL2:  state_in = BK_FIN;
         BK_FIN:   state_in = BK_OUT;
         BK_OUT:   if (load_out) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   // stencil tap contribution, weights 1 2 1
   always_comb begin
      pix_s   = GRAD_BITS'(signed'({1'b0, ram_rd_data}));
      mx      = (d_tr_ff == 2'd1) ? (pix_s <<< 1) : pix_s;
      my      = (d_tc_ff == 2'd1) ? (pix_s <<< 1) : pix_s;
      gx_base = (d_tr_ff == 2'd0 && d_tc_ff == 2'd0) ? '0 : gx_acc_ff;
      gy_base = (d_tr_ff == 2'd0 && d_tc_ff == 2'd0) ? '0 : gy_acc_ff;
      gx_in   = gx_base;
      gy_in   = gy_base;
      if (d_tc_ff == 2'd0) gx_in = gx_base - mx;
      if (d_tc_ff == 2'd2) gx_in = gx_base + mx;
      if (d_tr_ff == 2'd0) gy_in = gy_base - my;
      if (d_tr_ff == 2'd2) gy_in = gy_base + my;
   end

   always_comb begin
      s_sum  = sa_ff + sc_ff;
      q_full = (63'(hk_ff) << 24) + 63'(lk_ff);
      val    = VAL_BITS'(ac_ff) - VAL_BITS'(bb_ff) - VAL_BITS'(q_full >> 16);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= (state_ff == BK_RUN);
         g_valid_ff <= d_valid_ff && (d_tr_ff == 2'd2) && (d_tc_ff == 2'd2);
      end
   end

   always_ff @(posedge clock) begin
      d_tr_ff <= tr_ff;
      d_tc_ff <= tc_ff;
      if (job_pop) begin
         col_ff <= job_data[CI-1:0];
         row_ff <= job_data[CI +: ROW_BITS];
         fe_ff  <= job_data[CI + ROW_BITS];
         r0_ff  <= mirror(mir_type'(job_data[CI +: ROW_BITS]) - mir_type'(1), h_m);
         c0_ff  <= mirror(mir_type'(job_data[CI-1:0]) - mir_type'(1), w_m);
         tr_ff  <= '0;
         tc_ff  <= '0;
         win_ff <= '0;
         sa_ff  <= '0;
         sb_ff  <= '0;
         sc_ff  <= '0;
      end else begin
         if (state_ff == BK_RUN) begin
            tc_ff <= (tc_ff == 2'd2) ? 2'd0 : tc_ff + 2'd1;
            if (tc_ff == 2'd2) begin
               tr_ff <= (tr_ff == 2'd2) ? 2'd0 : tr_ff + 2'd1;
               if (tr_ff == 2'd2) win_ff <= win_ff + 2'd1;
            end
         end
         if (g_valid_ff) begin
            sa_ff <= sa_ff + SUM_BITS'(gx_ff * gx_ff);
            sb_ff <= sb_ff + SUM_BITS'(gx_ff * gy_ff);
            sc_ff <= sc_ff + SUM_BITS'(gy_ff * gy_ff);
         end
      end
      if (d_valid_ff) begin
         gx_acc_ff <= gx_in;
         gy_acc_ff <= gy_in;
         if (d_tr_ff == 2'd2 && d_tc_ff == 2'd2) begin
            gx_ff <= gx_in;
            gy_ff <= gy_in;
         end
      end
      if (state_ff == BK_MUL1) begin
         ac_ff <= PROD_BITS'(sa_ff * sc_ff);
         bb_ff <= PROD_BITS'(sb_ff * sb_ff);
         ss_ff <= PROD_BITS'($unsigned(s_sum) * $unsigned(s_sum));
      end
      if (state_ff == BK_MUL2) begin
         hk_ff <= 39'(ss_ff[47:24] * k_gain);
         lk_ff <= 39'(ss_ff[23:0] * k_gain);
      end
      if (state_ff == BK_FIN) begin
         if (val > RESP_LIMIT) res_ff <= RESP_BITS'(RESP_LIMIT);
         else if (val < -RESP_LIMIT) res_ff <= RESP_BITS'(-RESP_LIMIT);
         else res_ff <= RESP_BITS'(val);
      end
      if (load_out) begin
         rsp_data_ff <= res_ff;
         rsp_last_ff <= fe_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RESP_DATA_BITS - RESP_BITS){1'b0}}, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: hdl/harris_corner_response_unit.sv
// ----------------------------------------------------------------------------
// harris_corner_response_unit
// Harris corner response over a raster stream of grey pixels.
// ----------------------------------------------------------------------------
// Pixels of a frame arrive on req_ in raster order, followed by 2*W+2 flush
// words (tuser high); the response of pixel p appears 2*W+2 words after it,
// with tlast on the frame's last pixel. The front stores a pixel in a ring of
// eight lines per cycle unless the job queue is full; the back takes a job,
// reads the pixel's four 3x3 stencils from that ring one tap a cycle, waits
// on the read, forms the products and the clamped response and loads the
// output register, at a pace set by the ring's single read port. A new frame
// is taken only once the back has finished the previous frame's last response.
// ----------------------------------------------------------------------------
module harris_corner_response_unit #(
   parameter int MAX_WIDTH = hcr_pkg::DEF_MAX_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [hcr_pkg::PIX_BITS-1:0]        req_tdata,  // pixel[7:0]
   input  logic                                req_tuser,  // pad
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [hcr_pkg::RESP_DATA_BITS-1:0]  rsp_tdata,  // response[44:0], zero fill
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hcr_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [hcr_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import hcr_pkg::*;

   localparam int CI = $clog2(MAX_WIDTH);
   localparam int WB = $clog2(MAX_WIDTH + 1);
   localparam int AW = RING_BITS + CI;
   localparam int JW = ROW_BITS + CI + 1;

   logic [K_BITS-1:0]   k_ff;
   logic [FW_BITS-1:0]  fw_ff;
   logic [HGT_BITS-1:0] fh_ff;

   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr, ram_rd_addr;
   logic [PIX_BITS-1:0] ram_wr_data, ram_rd_data;
   logic [WB-1:0]     act_width;
   logic [HGT_BITS-1:0] act_height;
   logic              job_push, job_pop, job_full, job_empty, back_idle;
   logic [JW-1:0]     job_in, job_out;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff  <= K_RESET;
         fw_ff <= FW_RESET;
         fh_ff <= FH_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_K_GAIN:       k_ff  <= csr_data[K_BITS-1:0];
            CSR_FRAME_WIDTH:  fw_ff <= csr_data[FW_BITS-1:0];
            CSR_FRAME_HEIGHT: fh_ff <= csr_data[HGT_BITS-1:0];
            default: ;
         endcase
      end
   end

   hcr_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .frame_width  (fw_ff),
      .frame_height (fh_ff),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .act_width    (act_width),
      .act_height   (act_height),
      .job_push     (job_push),
      .job_data     (job_in),
      .job_full     (job_full),
      .job_empty    (job_empty),
      .back_idle    (back_idle)
   );

   hcr_ram #(.WIDTH(PIX_BITS), .DEPTH(RING_ROWS << CI)) u_lines (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   hcr_fifo #(.WIDTH(JW), .DEPTH(QUEUE_DEPTH)) u_jobs (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .pop       (job_pop),
      .pop_data  (job_out),
      .empty     (job_empty),
      .full      (job_full)
   );

   hcr_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_data    (job_out),
      .job_empty   (job_empty),
      .job_pop     (job_pop),
      .back_idle   (back_idle),
      .act_width   (act_width),
      .act_height  (act_height),
      .k_gain      (k_ff),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

FILE: dv/tb_harris_corner_response_unit.sv
// ----------------------------------------------------------------------------
// tb_harris_corner_response_unit
// Self-checking bench for the Harris corner response unit.
// ----------------------------------------------------------------------------
// Sets the frame size and gain over the csr port between frames, streams
// frames of pixels plus their flush words, and compares every response
// word with a bench-side model of the Sobel, box-sum and response stages.
// Covers a short table of directed words first, then random frames with
// stray pad words, pixels in the flush part, clamped sizes, wide and tall
// frames and a saturating gain. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_harris_corner_response_unit;
   import hcr_pkg::*;

   localparam logic signed [44:0] SAT_HI = 45'sd17318914560000;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd3;

   logic                        clock;
   logic                        reset;
   logic                        req_tvalid;
   logic                        req_tready;
   logic [PIX_BITS-1:0]         req_tdata;
   logic                        req_tuser;
   logic                        rsp_tvalid;
   logic                        rsp_tready;
   logic [RESP_DATA_BITS-1:0]   rsp_tdata;
   logic                        rsp_tlast;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_INDEX_BITS-1:0]   csr_index;
   logic [CSR_DATA_BITS-1:0]    csr_data;

   harris_corner_response_unit uut (.*);

   typedef struct {
      logic signed [44:0] resp;
      bit                 last;
   } resp_word_type;

   typedef struct {
      logic [7:0] px;
      bit         pd;
      bit         has_resp;
      bit         last;
   } table_row_type;

   resp_word_type resp_due[$];
   logic [7:0]  ring_px [0:7][0:1023];
   int unsigned frame_pos, act_w, act_h;
   int unsigned k_reg, fw_reg, fh_reg;
   int          fails, words_sent, resp_seen, frames_sent;
   int          rsp_hold;
   bit          rsp_took, no_gaps;

   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   initial begin
      #200000000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int mir(input int i, input int n);
      int v;
      v = i;
      if (v < 0) v = -v;
      if (v >= n) v = 2 * n - 2 - v;
      if (v < 0) v = 0;
      return v;
   endfunction

   function automatic int px_at(input int r, input int c);
      return int'(ring_px[mir(r, act_h) & 7][mir(c, act_w)]);
   endfunction

   function automatic longint corner_at(input int r, input int c);
      int rr[2], cc[2];
      int gx, gy, y, x;
      longint sa, sb, sc, v;
      longint unsigned s, q;
      sa = 0; sb = 0; sc = 0;
      rr[0] = mir(r - 1, act_h); rr[1] = r;
      cc[0] = mir(c - 1, act_w); cc[1] = c;
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++) begin
            y = rr[i]; x = cc[j];
            gx = (px_at(y-1, x+1) - px_at(y-1, x-1)) + 2 * (px_at(y, x+1) - px_at(y, x-1))
               + (px_at(y+1, x+1) - px_at(y+1, x-1));
            gy = (px_at(y+1, x-1) - px_at(y-1, x-1)) + 2 * (px_at(y+1, x) - px_at(y-1, x))
               + (px_at(y+1, x+1) - px_at(y-1, x+1));
            sa += longint'(gx) * gx;
            sb += longint'(gx) * gy;
            sc += longint'(gy) * gy;
         end
      s = longint'(sa + sc);
      q = (s * s * longint'(k_reg)) >> 16;
      v = sa * sc - sb * sb - longint'(q);
      if (v > longint'(SAT_HI)) v = longint'(SAT_HI);
      if (v < -longint'(SAT_HI)) v = -longint'(SAT_HI);
      return v;
   endfunction

   // advance the model by one accepted word; returns 1 when a response is due
   function automatic bit predict_word(input logic [7:0] p, input bit pd,
                                       output resp_word_type w);
      int unsigned total, lat, pos;
      longint v;
      w.resp = '0; w.last = 1'b0;
      if (frame_pos == 0) begin
         if (pd) return 1'b0;
         act_w = (fw_reg < 3) ? 3 : (fw_reg > 1024 ? 1024 : fw_reg);
         act_h = (fh_reg < 3) ? 3 : (fh_reg > 1024 ? 1024 : fh_reg);
      end
      total = act_w * act_h;
      lat = 2 * act_w + 2;
      if (frame_pos < total) begin
         if (pd) return 1'b0;
         ring_px[(frame_pos / act_w) & 7][frame_pos % act_w] = p;
      end
      predict_word = 1'b0;
      if (frame_pos >= lat) begin
         pos = frame_pos - lat;
         v = corner_at(pos / act_w, pos % act_w);
         w.resp = v[44:0];
         w.last = (pos == total - 1);
         predict_word = 1'b1;
      end
      frame_pos++;
      if (frame_pos >= total + lat) frame_pos = 0;
   endfunction

   function automatic int draw_gap();
      return no_gaps ? 0 : $urandom_range(0, 11);
   endfunction

   // drive one word and hold it until taken
   task automatic send_word(input logic [7:0] p, input bit pd, output bit due,
                            output resp_word_type w);
      int g;
      g = draw_gap();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= p;
      req_tuser  <= pd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      due = predict_word(p, pd, w);
      @(negedge clock);
   endtask

   task automatic push_word(input logic [7:0] p, input bit pd);
      bit due;
      resp_word_type w;
      send_word(p, pd, due, w);
      if (due) resp_due.push_back(w);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_K_GAIN:       k_reg  = d;
         CSR_FRAME_WIDTH:  fw_reg = d & 15'h7ff;
         CSR_FRAME_HEIGHT: fh_reg = d & 15'h7ff;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // hold until every response has left, then let the back drain
   task automatic drain();
      req_tvalid <= 1'b0;
      while (resp_due.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic send_frame(input int style);
      int w, h, stop_at;
      logic [7:0] p;
      w = (fw_reg < 3) ? 3 : (fw_reg > 1024 ? 1024 : fw_reg);
      h = (fh_reg < 3) ? 3 : (fh_reg > 1024 ? 1024 : fh_reg);
      stop_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, w * h - 1) : -1;
      if ($urandom_range(0, 5) == 0) push_word(8'($urandom), 1'b1);
      for (int i = 0; i < w * h; i++) begin
         if (i == stop_at) begin
            req_tvalid <= 1'b0;
            while (resp_due.size() != 0) @(negedge clock);
         end
         if ($urandom_range(0, 19) == 0) push_word(8'($urandom), 1'b1);
         case (style)
            0:       p = 8'($urandom);
            1:       p = (((i % w) + (i / w)) & 1) ? 8'hff : 8'h00;
            2:       p = $urandom_range(0, 1) ? 8'hff : 8'h00;
            default: p = 8'((i % w) * 9 + (i / w) * 5);
         endcase
         push_word(p, 1'b0);
      end
      for (int i = 0; i < 2 * w + 2; i++)
         push_word(8'($urandom), $urandom_range(0, 5) != 0);
      frames_sent++;
   endtask

   // checker
   always @(posedge clock) begin
      resp_word_type e;
      rsp_took = 1'b0;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_took = 1'b1;
         resp_seen++;
         if (resp_due.size() == 0) begin
            $error("response word with nothing due: %0d", $signed(rsp_tdata[44:0]));
            fails++;
         end else begin
            e = resp_due.pop_front();
            if ($signed(rsp_tdata[44:0]) !== e.resp) begin
               $error("response: expected %0d, got %0d", e.resp, $signed(rsp_tdata[44:0]));
               fails++;
            end
            if (rsp_tlast !== e.last) begin
               $error("frame_end: expected %0b, got %0b", e.last, rsp_tlast);
               fails++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_tready <= 1'b1;
         if (rsp_took) rsp_hold = no_gaps ? 0 : $urandom_range(0, 11);
      end
   end

   table_row_type dir_rows [18];

   initial begin
      bit due;
      resp_word_type w;
      int sizes[8][2];
      int k_pick;
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tuser = 1'b0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0; csr_index = '0; csr_data = '0;
      fails = 0; words_sent = 0; resp_seen = 0; frames_sent = 0;
      rsp_hold = 0; rsp_took = 1'b0; no_gaps = 1'b0;
      frame_pos = 0; act_w = 3; act_h = 3;
      k_reg = K_RESET; fw_reg = FW_RESET; fh_reg = FH_RESET;
      foreach (ring_px[i, j]) ring_px[i][j] = '0;

      // flat 3x3 frame: every response is zero, whatever the gain
      for (int i = 0; i < 18; i++) dir_rows[i] = '{8'hff, 1'b0, i >= 9, i == 17};
      dir_rows[4]  = '{8'h00, 1'b1, 1'b0, 1'b0};
      dir_rows[10] = '{8'h5a, 1'b0, 1'b1, 1'b0};
      for (int i = 11; i < 18; i++) begin
         dir_rows[i].px = 8'h00;
         dir_rows[i].pd = 1'b1;
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      repeat (4) @(negedge clock);

      csr_write(CSR_FRAME_WIDTH, 15'd3);
      csr_write(CSR_FRAME_HEIGHT, 15'd3);
      foreach (dir_rows[i]) begin
         send_word(dir_rows[i].px, dir_rows[i].pd, due, w);
         if (dir_rows[i].has_resp) resp_due.push_back('{45'sd0, dir_rows[i].last});
      end
      frames_sent++;
      drain();

      sizes = '{'{40, 3}, '{3, 40}, '{2, 0}, '{0, 2},
                '{1, 2}, '{2, 1}, '{4, 3}, '{3, 4}};
      for (int f = 0; f < 8; f++) begin
         no_gaps = f < 4;
         csr_write(CSR_FRAME_WIDTH, 15'(sizes[f][0]) | 15'($urandom_range(0, 15) << 11));
         csr_write(CSR_FRAME_HEIGHT, 15'(sizes[f][1]) | 15'($urandom_range(0, 15) << 11));
         csr_write(CSR_K_GAIN, (f == 6) ? 15'h7fff : (f == 7) ? 15'd16384 : 15'd0);
         send_frame(f % 4);
         drain();
      end

      while (words_sent < 1000) begin
         no_gaps = $urandom_range(0, 4) == 0;
         if ($urandom_range(0, 3) == 0) csr_write(CSR_SPARE, 15'($urandom));
         k_pick = $urandom_range(0, 5);
         csr_write(CSR_K_GAIN, k_pick == 0 ? 15'h7fff : k_pick == 1 ? 15'd0 :
                   k_pick == 2 ? 15'd16384 : 15'($urandom));
         csr_write(CSR_FRAME_WIDTH, 15'($urandom_range(3, 10)));
         csr_write(CSR_FRAME_HEIGHT, 15'($urandom_range(3, 9)));
         if ($urandom_range(0, 3) == 0) push_word(8'($urandom), 1'b1);
         send_frame($urandom_range(0, 3));
         drain();
      end

      $display("run: %0d frames, %0d input words, %0d response words checked",
               frames_sent, words_sent, resp_seen);
      $display("sizes from clamped minimum to 40 wide or tall, gain from 0 to saturation, "
               , "both sides stalled");
      if (fails == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
